/* src/sprq_pkg.sv */
`default_nettype none
package sprq_pkg;

    localparam int DEPTH         = 16;
    localparam int PRIORITY_BITS = 8;
    localparam int PAYLOAD_BITS  = 16;
    localparam int ADDR_W        = $clog2(DEPTH);
    localparam int CNT_W         = $clog2(DEPTH + 1);
    localparam int ENTRY_W       = PRIORITY_BITS + PAYLOAD_BITS;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [PRIORITY_BITS-1:0] pri;
        logic [PAYLOAD_BITS-1:0]  pay;
    } t_entry;

endpackage
`default_nettype wire

/* src/sprq_ram.sv */
`default_nettype none
module sprq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

/* src/stable_priority_queue.sv */
`default_nettype none
// Stable sorted priority queue of up to DEPTH entries; lower priority value
// leaves first, equal priorities leave in arrival order. Entries sit in one
// single-port-read RAM as a circular buffer in sorted order. One beat is
// taken at a time and o_stall stays high until its result beat has been
// taken. A remove reads the head entry and returns it; an insert dropped as
// full or a remove on an empty queue goes straight to the result beat with
// its status. An insert moves back one slot each held entry with a strictly
// higher priority value, starting from the tail: each move is a RAM read, a
// compare and a RAM write through the one compare unit, and the scan that
// stops on a lower or equal entry spends one more read and compare, then
// writes the new entry. The result beat is held while i_stall is high.
module stable_priority_queue (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic                              i_kind,
    input  wire logic [sprq_pkg::PRIORITY_BITS-1:0] i_new_priority,
    input  wire logic [sprq_pkg::PAYLOAD_BITS-1:0]  i_new_payload,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic                                   o_out_valid,
    output logic      [sprq_pkg::PRIORITY_BITS-1:0] o_out_priority,
    output logic      [sprq_pkg::PAYLOAD_BITS-1:0]  o_out_payload,
    output logic      [1:0]                        o_status,
    output logic      [sprq_pkg::CNT_W-1:0]         o_fill_count
);
    import sprq_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_POP   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [ADDR_W-1:0]  r_head, n_head;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [ADDR_W-1:0]  r_slot, n_slot;
    logic [CNT_W-1:0]   r_left, n_left;
    t_entry             r_new, n_new;
    logic               r_out_valid, n_out_valid;
    t_entry             r_out, n_out;
    logic [1:0]         r_status, n_status;

    logic               wr_en;
    t_entry             wr_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    t_entry             rd_data;
    logic [ADDR_W-1:0]  slot_prev;
    logic [ADDR_W-1:0]  head_next;
    logic [CNT_W:0]     tail_sum;
    logic [ADDR_W-1:0]  tail_addr;
    logic               accept;

    assign accept    = i_valid && (r_state == S_IDLE);
    assign slot_prev = (r_slot == '0) ? ADDR_W'(DEPTH - 1) : r_slot - 1'b1;
    assign head_next = (r_head == ADDR_W'(DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign tail_sum  = {1'b0, CNT_W'(r_head)} + {1'b0, r_count};
    assign tail_addr = (tail_sum >= (CNT_W + 1)'(DEPTH))
                     ? ADDR_W'(tail_sum - (CNT_W + 1)'(DEPTH))
                     : ADDR_W'(tail_sum);

    sprq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_slot),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_slot      = r_slot;
        n_left      = r_left;
        n_new       = r_new;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_status    = r_status;
        wr_en       = 1'b0;
        wr_data     = r_new;
        rd_en       = 1'b0;
        rd_addr     = slot_prev;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_new.pri   = i_new_priority;
                    n_new.pay   = i_new_payload;
                    n_out_valid = 1'b0;
                    n_out       = '0;
                    n_status    = STATUS_OK;
                    if (i_kind == KIND_INSERT) begin
                        if (r_count == CNT_W'(DEPTH)) begin
                            n_status = STATUS_FULL;
                            n_state  = S_OUT;
                        end else begin
                            n_slot  = tail_addr;
                            n_left  = r_count;
                            n_state = S_FETCH;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = STATUS_EMPTY;
                            n_state  = S_OUT;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = r_head;
                            n_state = S_POP;
                        end
                    end
                end
            end
            S_FETCH: begin
                if (r_left == '0) begin
                    wr_en   = 1'b1;
                    n_count = r_count + 1'b1;
                    n_state = S_OUT;
                end else begin
                    rd_en   = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                wr_en = 1'b1;
                if (rd_data.pri > r_new.pri) begin
                    wr_data = rd_data;
                    n_slot  = slot_prev;
                    n_left  = r_left - 1'b1;
                    n_state = S_FETCH;
                end else begin
                    n_count = r_count + 1'b1;
                    n_state = S_OUT;
                end
            end
            S_POP: begin
                n_out_valid = 1'b1;
                n_out       = rd_data;
                n_head      = head_next;
                n_count     = r_count - 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
        r_slot      <= n_slot;
        r_left      <= n_left;
        r_new       <= n_new;
        r_out_valid <= n_out_valid;
        r_out       <= n_out;
        r_status    <= n_status;
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = (r_state == S_OUT);
    assign o_out_valid    = r_out_valid;
    assign o_out_priority = r_out.pri;
    assign o_out_payload  = r_out.pay;
    assign o_status       = r_status;
    assign o_fill_count   = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_valid |-> o_status == STATUS_OK)
        else $error("returned entry with bad status");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == STATUS_FULL) |-> o_fill_count == CNT_W'(DEPTH))
        else $error("full flagged while not full");

    a_pop_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_kind == KIND_REMOVE) && (r_count != '0) |=> r_state == S_POP)
        else $error("remove did not read head");

endmodule
`default_nettype wire
